// File: rtl/core/rgbp_pkg.sv
// Package for the RGB888 to native pixel packer.
// Holds register indexes, storage mode codes and the stage payload types.
// No dependencies.
package rgbp_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RED_MASK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MASK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STORAGE_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MSB_FIRST    = 3'd4;

  localparam logic [1:0] MODE_32 = 2'd0;
  localparam logic [1:0] MODE_16 = 2'd1;
  localparam logic [1:0] MODE_24 = 2'd2;

  localparam logic [2:0] COUNT_32 = 3'd4;
  localparam logic [2:0] COUNT_16 = 3'd2;
  localparam logic [2:0] COUNT_24 = 3'd3;

  localparam logic [31:0] RED_MASK_RST   = 32'h00ff_0000;
  localparam logic [31:0] GREEN_MASK_RST = 32'h0000_ff00;
  localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00ff;

  localparam int unsigned NUM_CH = 3;

  typedef struct packed {
    logic [7:0] value;
    logic [5:0] width;
    logic [4:0] shift;
  } chan_t;

  typedef struct packed {
    logic [31:0] field;
    logic [4:0]  shift;
  } scaled_t;

endpackage

// File: rtl/core/rgbp_if.sv
// Valid/ready channel interfaces for the pixel packer.
// rgbp_in_if carries one RGB888 pixel, rgbp_out_if one packed pixel.
// No dependencies.
interface rgbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface rgbp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_bytes;
  logic [2:0]  byte_count;

  modport source (output valid, output packed_bytes, output byte_count, input ready);
  modport sink (input valid, input packed_bytes, input byte_count, output ready);
endinterface

// File: rtl/core/rgbp_mask_stage.sv
// First stage: width (set bits) and position (trailing zeros) of each mask.
// Registers them with the pixel channels. Depends on rgbp_pkg.
module rgbp_mask_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rgbp_pkg::NUM_CH-1:0][7:0]    value_i,
  input  logic [rgbp_pkg::NUM_CH-1:0][31:0]   mask_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rgbp_pkg::chan_t [rgbp_pkg::NUM_CH-1:0] chan_o
);
  import rgbp_pkg::*;

  logic                    valid_r;
  chan_t [NUM_CH-1:0]      chan_r;
  chan_t [NUM_CH-1:0]      chan_nxt;
  logic                    load;

  assign in_ready_o = !valid_r || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      chan_nxt[c].value = value_i[c];
      chan_nxt[c].width = 6'($countones(mask_i[c]));
      chan_nxt[c].shift = 5'd0;
      for (int b = 31; b >= 0; b--) begin
        if (mask_i[c][b]) begin
          chan_nxt[c].shift = 5'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready_o) begin
      valid_r <= in_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chan_r <= chan_nxt;
    end
  end

  assign out_valid_o = valid_r;
  assign chan_o      = chan_r;
endmodule

// File: rtl/core/rgbp_scale_stage.sv
// Second stage: rescale each channel to its mask width.
// Narrow channels round as (v*(2^w-1)+127)/255, wide ones shift left. Depends on rgbp_pkg.
module rgbp_scale_stage (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  rgbp_pkg::chan_t [rgbp_pkg::NUM_CH-1:0]   chan_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output rgbp_pkg::scaled_t [rgbp_pkg::NUM_CH-1:0] scaled_o
);
  import rgbp_pkg::*;

  logic                  valid_r;
  scaled_t [NUM_CH-1:0]  scaled_r;
  scaled_t [NUM_CH-1:0]  scaled_nxt;
  logic                  load;
  logic [7:0]            max_v   [NUM_CH];
  logic [15:0]           rounded [NUM_CH];
  logic [16:0]           quot    [NUM_CH];

  assign in_ready_o = !valid_r || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      max_v[c]   = 8'((9'd1 << chan_i[c].width[2:0]) - 9'd1);
      rounded[c] = 16'(chan_i[c].value) * 16'(max_v[c]) + 16'd127;
      // divide by 255 exactly for values below 2^16 - 1
      quot[c]    = ({1'b0, rounded[c]} + 17'(rounded[c] >> 8) + 17'd1) >> 8;
      scaled_nxt[c].shift = chan_i[c].shift;
      if (chan_i[c].width == 6'd0) begin
        scaled_nxt[c].field = 32'd0;
      end else if (chan_i[c].width >= 6'd8) begin
        scaled_nxt[c].field = {24'd0, chan_i[c].value} << (chan_i[c].width - 6'd8);
      end else begin
        scaled_nxt[c].field = {24'd0, quot[c][7:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready_o) begin
      valid_r <= in_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      scaled_r <= scaled_nxt;
    end
  end

  assign out_valid_o = valid_r;
  assign scaled_o    = scaled_r;
endmodule

// File: rtl/core/rgbp_pack_stage.sv
// Third stage: place the channels, merge them and order the bytes for storage.
// Holds the output register. Depends on rgbp_pkg.
module rgbp_pack_stage (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  rgbp_pkg::scaled_t [rgbp_pkg::NUM_CH-1:0] scaled_i,
  input  logic [1:0]                            storage_mode_i,
  input  logic                                  msb_first_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [31:0]                           packed_bytes_o,
  output logic [2:0]                            byte_count_o
);
  import rgbp_pkg::*;

  logic        valid_r;
  logic [31:0] bytes_r;
  logic [31:0] bytes_nxt;
  logic [2:0]  count_r;
  logic [2:0]  count_nxt;
  logic [31:0] word;
  logic        load;

  assign in_ready_o = !valid_r || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    word = 32'd0;
    for (int c = 0; c < NUM_CH; c++) begin
      word = word | (scaled_i[c].field << scaled_i[c].shift);
    end
  end

  always_comb begin
    case (storage_mode_i)
      MODE_16: begin
        bytes_nxt = msb_first_i ? {16'd0, word[7:0], word[15:8]} : {16'd0, word[15:0]};
        count_nxt = COUNT_16;
      end
      MODE_24: begin
        bytes_nxt = msb_first_i ? {8'd0, word[7:0], word[15:8], word[23:16]}
                                : {8'd0, word[23:0]};
        count_nxt = COUNT_24;
      end
      default: begin
        bytes_nxt = msb_first_i ? {word[7:0], word[15:8], word[23:16], word[31:24]} : word;
        count_nxt = COUNT_32;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready_o) begin
      valid_r <= in_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= bytes_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_valid_o    = valid_r;
  assign packed_bytes_o = bytes_r;
  assign byte_count_o   = count_r;
endmodule

// File: rtl/core/rgb888_to_native_pixel_pack.sv
// RGB888 to native pixel packer, top level: config registers and three pipeline stages.
// Pipeline: an accepted input passes the mask, scale and pack stage registers in order.
// Throughput: one item per cycle; each stage advances when its successor has room.
// Reset (rst_n, synchronous): empties the pipeline, masks to 0x00ff0000/0x0000ff00/
// 0x000000ff, 32-bit storage, least significant byte first.
// Depends on rgbp_pkg, rgbp_if, rgbp_mask_stage, rgbp_scale_stage, rgbp_pack_stage.
module rgb888_to_native_pixel_pack (
  input  logic                                clk,
  input  logic                                rst_n,
  rgbp_in_if.sink                             in_if,
  rgbp_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [rgbp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgbp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import rgbp_pkg::*;

  logic [NUM_CH-1:0][31:0] mask_r;
  logic [1:0]              storage_mode_r;
  logic                    msb_first_r;

  logic [NUM_CH-1:0][7:0]  pix_value;
  logic                    s1_valid;
  logic                    s1_ready;
  chan_t [NUM_CH-1:0]      s1_chan;
  logic                    s2_valid;
  logic                    s2_ready;
  scaled_t [NUM_CH-1:0]    s2_scaled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r[0]      <= RED_MASK_RST;
      mask_r[1]      <= GREEN_MASK_RST;
      mask_r[2]      <= BLUE_MASK_RST;
      storage_mode_r <= MODE_32;
      msb_first_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RED_MASK:     mask_r[0]      <= cfg_wdata;
        REG_GREEN_MASK:   mask_r[1]      <= cfg_wdata;
        REG_BLUE_MASK:    mask_r[2]      <= cfg_wdata;
        REG_STORAGE_MODE: storage_mode_r <= cfg_wdata[1:0];
        REG_MSB_FIRST:    msb_first_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign pix_value[0] = in_if.red_in;
  assign pix_value[1] = in_if.green_in;
  assign pix_value[2] = in_if.blue_in;

  rgbp_mask_stage u_mask (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .value_i     (pix_value),
    .mask_i      (mask_r),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .chan_o      (s1_chan)
  );

  rgbp_scale_stage u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .chan_i      (s1_chan),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .scaled_o    (s2_scaled)
  );

  rgbp_pack_stage u_pack (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid_i     (s2_valid),
    .in_ready_o     (s2_ready),
    .scaled_i       (s2_scaled),
    .storage_mode_i (storage_mode_r),
    .msb_first_i    (msb_first_r),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .packed_bytes_o (out_if.packed_bytes),
    .byte_count_o   (out_if.byte_count)
  );
endmodule
